/* design/stm_pkg.sv */
package stm_pkg;

  // Character codes
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;

  // Scanner modes
  localparam logic [2:0] MODE_NORMAL    = 3'd0;
  localparam logic [2:0] MODE_AFTER_ID  = 3'd1;
  localparam logic [2:0] MODE_ID_WS     = 3'd2;
  localparam logic [2:0] MODE_DIRECTIVE = 3'd3;
  localparam logic [2:0] MODE_QUOTE     = 3'd4;
  localparam logic [2:0] MODE_QUOTE_ESC = 3'd5;

  localparam int MAX_RES = 3;

  // Results caused by one input item
  typedef struct packed {
    logic [1:0]               cnt;       // number of results, 0..3
    logic [MAX_RES-1:0][7:0]  bytes;     // result bytes, first in slot 0
    logic                     marker;    // single result carries no byte
    logic                     text_end;  // last result closes the text
  } bundle_t;

  function automatic logic is_id_char(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h30 && c <= 8'h39) || c == CH_UNDER;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB;
  endfunction

  function automatic logic is_line_end(input logic [7:0] c);
    return c == CH_LF || c == CH_CR;
  endfunction

endpackage

/* design/shader_text_minifier.sv */
// An accepted item sits in the input register while the scanner works out its
// results combinationally; they are loaded into the result register and offered
// from there one at a time.
// One item per cycle when it gives at most one result and the receiver is ready;
// an item giving two or three results holds the result register until all are taken.
// Reset (rst, synchronous, active high) empties both registers and returns
// the scanner to normal mode with no directive pending.
module shader_text_minifier import stm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // in_byte
  input  logic       s_tlast,   // text_end
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // out_byte
  output logic       m_tlast,   // run_last
  output logic [1:0] m_tuser    // [0] byte_valid, [1] output_end
);

  logic       hold_valid;
  logic [7:0] hold_byte;
  logic       hold_end;
  logic       take;
  logic       advance;
  bundle_t    bundle;

  assign advance = hold_valid && take;
  assign s_tready = !hold_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (s_tready) begin
      hold_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      hold_byte <= s_tdata;
      hold_end <= s_tlast;
    end
  end

  stm_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .hold_byte (hold_byte),
    .hold_end  (hold_end),
    .advance   (advance),
    .bundle    (bundle)
  );

  stm_outbuf u_outbuf (
    .clk      (clk),
    .rst      (rst),
    .bundle   (bundle),
    .load_req (hold_valid),
    .take     (take),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  // Checks
  a_rst_empty: assert property (@(posedge clk) rst |=> !m_tvalid && !hold_valid)
    else $error("buffers not empty after reset");
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tlast)
    else $error("end of text not on last item of its run");
  a_marker_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tuser[1] && m_tdata == 8'h00)
    else $error("marker item outside end of text");
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    hold_valid && !advance |=> hold_valid && $stable(hold_byte) && $stable(hold_end))
    else $error("input register lost a stalled item");

endmodule

/* design/stm_scan.sv */
module stm_scan import stm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] hold_byte,
  input  logic       hold_end,
  input  logic       advance,
  output bundle_t    bundle
);

  logic [2:0] scan_mode, scan_mode_next;
  logic       quote_is_double, quote_is_double_next;
  logic       directive_spaced, directive_spaced_next;
  logic       last_was_directive, last_was_directive_next;

  logic [1:0]              n;
  logic [MAX_RES-1:0][7:0] res;
  logic                    marker;
  logic [7:0]              c;
  logic [7:0]              close_q;

  assign c = hold_byte;
  assign close_q = quote_is_double ? CH_DQ : CH_SQ;

  // Per-item decision: results and next scanner state
  always_comb begin
    n = 2'd0;
    res = '0;
    marker = 1'b0;
    scan_mode_next = scan_mode;
    quote_is_double_next = quote_is_double;
    directive_spaced_next = directive_spaced;
    last_was_directive_next = last_was_directive;

    if (scan_mode == MODE_DIRECTIVE) begin
      if (is_line_end(c)) begin
        res[n] = CH_LF; n = n + 2'd1;
        scan_mode_next = MODE_NORMAL;
      end else if (is_blank(c)) begin
        if (!directive_spaced) begin
          res[n] = c; n = n + 2'd1;
          directive_spaced_next = 1'b1;
        end
      end else begin
        res[n] = c; n = n + 2'd1;
        directive_spaced_next = 1'b0;
      end
    end else if (scan_mode == MODE_QUOTE) begin
      res[n] = c; n = n + 2'd1;
      if (c == CH_BSL) scan_mode_next = MODE_QUOTE_ESC;
      else if (c == close_q) scan_mode_next = MODE_NORMAL;
    end else if (scan_mode == MODE_QUOTE_ESC) begin
      res[n] = c; n = n + 2'd1;
      scan_mode_next = MODE_QUOTE;
    end else if (is_id_char(c)) begin
      if (scan_mode == MODE_ID_WS) begin
        res[n] = CH_SPACE; n = n + 2'd1;
      end
      res[n] = c; n = n + 2'd1;
      scan_mode_next = MODE_AFTER_ID;
      last_was_directive_next = 1'b0;
    end else if (is_blank(c) || is_line_end(c)) begin
      if (scan_mode == MODE_AFTER_ID) scan_mode_next = MODE_ID_WS;
    end else if (c == CH_HASH) begin
      if (!last_was_directive) begin
        res[n] = CH_LF; n = n + 2'd1;
      end
      res[n] = c; n = n + 2'd1;
      scan_mode_next = MODE_DIRECTIVE;
      directive_spaced_next = 1'b0;
      last_was_directive_next = 1'b1;
    end else if (c == CH_SQ || c == CH_DQ) begin
      res[n] = c; n = n + 2'd1;
      quote_is_double_next = (c == CH_DQ);
      scan_mode_next = MODE_QUOTE;
      last_was_directive_next = 1'b0;
    end else begin
      res[n] = c; n = n + 2'd1;
      scan_mode_next = MODE_NORMAL;
      last_was_directive_next = 1'b0;
    end

    // End of text: closing newline, marker if nothing left, state back to reset
    if (hold_end) begin
      if (scan_mode_next == MODE_DIRECTIVE || !last_was_directive_next) begin
        res[n] = CH_LF; n = n + 2'd1;
      end
      if (n == 2'd0) begin
        marker = 1'b1;
        n = 2'd1;
      end
      scan_mode_next = MODE_NORMAL;
      quote_is_double_next = 1'b0;
      directive_spaced_next = 1'b0;
      last_was_directive_next = 1'b1;
    end
  end

  assign bundle.cnt = n;
  assign bundle.bytes = res;
  assign bundle.marker = marker;
  assign bundle.text_end = hold_end;

  // Scanner state
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode <= MODE_NORMAL;
      quote_is_double <= 1'b0;
      directive_spaced <= 1'b0;
      last_was_directive <= 1'b1;
    end else if (advance) begin
      scan_mode <= scan_mode_next;
      quote_is_double <= quote_is_double_next;
      directive_spaced <= directive_spaced_next;
      last_was_directive <= last_was_directive_next;
    end
  end

endmodule

/* design/stm_outbuf.sv */
module stm_outbuf import stm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  bundle_t    bundle,
  input  logic       load_req,
  output logic       take,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // out_byte
  output logic       m_tlast,   // run_last
  output logic [1:0] m_tuser    // [0] byte_valid, [1] output_end
);

  logic [1:0]              cnt;
  logic [1:0]              idx;
  logic [MAX_RES-1:0][7:0] data;
  logic                    marker;
  logic                    text_end;
  logic                    at_last;
  logic                    load;

  assign at_last = (idx == cnt - 2'd1);
  assign m_tvalid = (cnt != 2'd0);
  // free for a new bundle when empty or its last item leaves now
  assign take = (cnt == 2'd0) || (m_tready && at_last);
  assign load = load_req && take;

  assign m_tdata = marker ? 8'h00 : data[idx];
  assign m_tlast = at_last;
  assign m_tuser = {text_end && at_last, !marker};

  // Result register: holds one bundle and walks through its items
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
      idx <= 2'd0;
    end else if (load) begin
      cnt <= bundle.cnt;
      idx <= 2'd0;
    end else if (m_tvalid && m_tready) begin
      if (at_last) cnt <= 2'd0;
      else idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= bundle.bytes;
      marker <= bundle.marker;
      text_end <= bundle.text_end;
    end
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
module tb;
  import stm_pkg::*;

  // Predicts the minified stream and checks what the block gives back
  class minify_scoreboard;
    typedef struct packed {
      logic [7:0] data;
      logic       valid;
      logic       last;
      logic       fin;
    } result_t;

    result_t    minified_q[$];
    result_t    step_q[$];
    logic [2:0] mode;
    logic       quote_dq;
    logic       dir_spaced;
    logic       after_dir;
    int         errors;
    int         checked;
    int         accepted;

    function new();
      restart();
      errors   = 0;
      checked  = 0;
      accepted = 0;
    endfunction

    function void restart();
      mode       = MODE_NORMAL;
      quote_dq   = 1'b0;
      dir_spaced = 1'b0;
      after_dir  = 1'b1;
    endfunction

    function bit word_char(logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h30 && c <= 8'h39) || c == CH_UNDER;
    endfunction

    function bit blank_char(logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB;
    endfunction

    function bit line_break(logic [7:0] c);
      return c == CH_LF || c == CH_CR;
    endfunction

    function void put(logic [7:0] c, logic v);
      result_t r;
      r.data  = c;
      r.valid = v;
      r.last  = 1'b0;
      r.fin   = 1'b0;
      step_q.push_back(r);
    endfunction

    function int pending();
      return minified_q.size();
    endfunction

    // Works out the results of one accepted source byte
    function void take_source_byte(logic [7:0] c, logic fin);
      result_t    r;
      logic [7:0] closer;
      accepted++;
      closer = quote_dq ? CH_DQ : CH_SQ;
      case (mode)
        MODE_DIRECTIVE: begin
          if (line_break(c)) begin
            put(CH_LF, 1'b1);
            mode = MODE_NORMAL;
          end else if (blank_char(c)) begin
            if (!dir_spaced) begin
              put(c, 1'b1);
              dir_spaced = 1'b1;
            end
          end else begin
            put(c, 1'b1);
            dir_spaced = 1'b0;
          end
        end
        MODE_QUOTE: begin
          put(c, 1'b1);
          if (c == CH_BSL) mode = MODE_QUOTE_ESC;
          else if (c == closer) mode = MODE_NORMAL;
        end
        MODE_QUOTE_ESC: begin
          put(c, 1'b1);
          mode = MODE_QUOTE;
        end
        default: begin
          if (word_char(c)) begin
            if (mode == MODE_ID_WS) put(CH_SPACE, 1'b1);
            put(c, 1'b1);
            mode      = MODE_AFTER_ID;
            after_dir = 1'b0;
          end else if (blank_char(c) || line_break(c)) begin
            if (mode == MODE_AFTER_ID) mode = MODE_ID_WS;
          end else if (c == CH_HASH) begin
            if (!after_dir) put(CH_LF, 1'b1);
            put(c, 1'b1);
            mode       = MODE_DIRECTIVE;
            dir_spaced = 1'b0;
            after_dir  = 1'b1;
          end else if (c == CH_SQ || c == CH_DQ) begin
            put(c, 1'b1);
            quote_dq  = (c == CH_DQ);
            mode      = MODE_QUOTE;
            after_dir = 1'b0;
          end else begin
            put(c, 1'b1);
            mode      = MODE_NORMAL;
            after_dir = 1'b0;
          end
        end
      endcase

      // end of text: closing newline, or a bare marker when nothing came out
      if (fin) begin
        if (mode == MODE_DIRECTIVE) put(CH_LF, 1'b1);
        else if (!after_dir) put(CH_LF, 1'b1);
        if (step_q.size() == 0) put(8'h00, 1'b0);
        r = step_q.pop_back();
        r.fin = 1'b1;
        step_q.push_back(r);
        restart();
      end
      if (step_q.size() > 0) begin
        r = step_q.pop_back();
        r.last = 1'b1;
        step_q.push_back(r);
      end
      while (step_q.size() > 0) minified_q.push_back(step_q.pop_front());
    endfunction

    task report_mismatch(string msg);
      if (errors < 30) $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_minified(logic [7:0] data, logic last, logic valid, logic fin);
      result_t e;
      checked++;
      if (minified_q.size() == 0) begin
        report_mismatch($sformatf("unexpected item data=%02h last=%0b valid=%0b end=%0b",
                                  data, last, valid, fin));
      end else begin
        e = minified_q.pop_front();
        if (data !== e.data || last !== e.last || valid !== e.valid || fin !== e.fin)
          report_mismatch($sformatf(
            "got data=%02h last=%0b valid=%0b end=%0b, want %02h %0b %0b %0b",
            data, last, valid, fin, e.data, e.last, e.valid, e.fin));
      end
    endtask
  endclass

  localparam int LIMIT       = 200000;
  localparam int ITEM_TARGET = 430;

  logic       clk      = 1'b0;
  logic       rst      = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata  = 8'h00;
  logic       s_tlast  = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;
  logic [1:0] m_tuser;

  minify_scoreboard sb = new();
  logic [7:0] src_q[$];
  int         cycles   = 0;
  int         n_sent   = 0;
  int         n_texts  = 0;
  bit         calm     = 1'b0;

  shader_text_minifier dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  // Receiver back-pressure
  always @(posedge clk) begin
    m_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 8);
  end

  // Handshake monitor on both sides
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      if (s_tvalid && s_tready) sb.take_source_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready) sb.check_minified(m_tdata, m_tlast, m_tuser[0], m_tuser[1]);
    end
  end

  // Watchdog
  initial begin
    while (cycles < LIMIT) @(posedge clk);
    $display("FAILED: results differ");
    $finish;
  end

  task automatic send_item(logic [7:0] b, logic fin);
    if (!calm && $urandom_range(0, 99) < 8) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= fin;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    n_sent++;
  endtask

  task automatic send_text();
    for (int i = 0; i < src_q.size(); i++) send_item(src_q[i], i == src_q.size() - 1);
    src_q.delete();
    n_texts++;
  endtask

  // Hold the sender until the expected stream is empty
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic push_str(string s);
    for (int i = 0; i < s.len(); i++) src_q.push_back(s[i]);
  endtask

  function automatic logic [7:0] rand_word_char();
    int unsigned r;
    r = $urandom_range(0, 62);
    if (r < 26) return 8'(8'h61 + r);
    if (r < 52) return 8'(8'h41 + (r - 26));
    if (r < 62) return 8'(8'h30 + (r - 52));
    return CH_UNDER;
  endfunction

  function automatic logic [7:0] rand_space();
    case ($urandom_range(0, 3))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_LF;
      default: return CH_CR;
    endcase
  endfunction

  function automatic logic [7:0] rand_punct();
    string p;
    p = "(){};,+-*/=<>.[]!&|?:~%^";
    return p[$urandom_range(0, p.len() - 1)];
  endfunction

  // Appends one shader-like token, or a broken one, to the source text
  task automatic add_token();
    int unsigned r;
    logic [7:0]  q;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      repeat ($urandom_range(1, 5)) src_q.push_back(rand_word_char());
    end else if (r < 52) begin
      repeat ($urandom_range(1, 3)) src_q.push_back(rand_space());
    end else if (r < 72) begin
      src_q.push_back(rand_punct());
    end else if (r < 80) begin
      // directive with blank runs, usually terminated
      src_q.push_back(CH_HASH);
      repeat ($urandom_range(1, 3)) begin
        repeat ($urandom_range(0, 3))
          src_q.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
        repeat ($urandom_range(1, 4))
          src_q.push_back($urandom_range(0, 4) == 0 ? rand_punct() : rand_word_char());
      end
      if ($urandom_range(0, 9) < 8) src_q.push_back($urandom_range(0, 1) ? CH_LF : CH_CR);
    end else if (r < 90) begin
      // quoted literal with escapes, sometimes left open
      q = $urandom_range(0, 1) ? CH_DQ : CH_SQ;
      src_q.push_back(q);
      repeat ($urandom_range(0, 5)) begin
        if ($urandom_range(0, 99) < 20) begin
          src_q.push_back(CH_BSL);
          src_q.push_back($urandom_range(0, 3) == 0 ? q : 8'($urandom_range(0, 255)));
        end else begin
          src_q.push_back($urandom_range(0, 1) ? rand_word_char() :
                          8'($urandom_range(0, 255)));
        end
      end
      if ($urandom_range(0, 99) < 85) src_q.push_back(q);
    end else begin
      src_q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: blank-only text gives a bare end marker
    push_str(" ");
    send_text();
    // identifiers split by a tab, last item gives three results
    push_str("a\t_");
    send_text();
    // directive after code, blank runs, CR end, text ends inside a directive
    push_str("x;#d \t e");
    src_q.push_back(CH_CR);
    push_str("#f");
    send_text();
    // literal with escaped quote, zero and top bytes, open literal at end
    push_str("\"a\\\"b\"");
    src_q.push_back(8'h00);
    src_q.push_back(8'hFF);
    push_str("'");
    send_text();
    // directive alone, at the start of a text
    push_str("#");
    send_text();
    drain();

    // Random texts
    while (n_sent < ITEM_TARGET) begin
      calm = (n_sent >= 200 && n_sent < 300);
      repeat ($urandom_range(1, 10)) add_token();
      send_text();
      if (n_texts % 10 == 5) drain();
    end

    calm = 1'b0;
    s_tvalid <= 1'b0;
    @(posedge clk);
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d source bytes in %0d texts; checked %0d minified items.",
             sb.accepted, n_texts, sb.checked);
    $display("Mix: identifiers, blanks, directives, literals with escapes, raw bytes.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      if (sb.pending() != 0) $display("%0d expected items never arrived", sb.pending());
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
